FILE: design/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg: shared types and constants of the sequence reorder buffer
// Window geometry, result status codes and the command/status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

  // window geometry
  localparam int WINDOW      = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(WINDOW);
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // payload widths
  localparam int SEQ_W    = 32;
  localparam int PAY_W    = 64;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 32;

  // input operation codes
  localparam logic OP_ITEM  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_WIN = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CLOSED_OK  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLOSED_GAP = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;       // capture the accepted input transfer
    logic emit_close;    // report close and clear the window
    logic emit_reject;   // report duplicate or out-of-window item
    logic store_write;   // write the item into its window slot
    logic emit_release;  // release the head slot in order
  } srb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_close;      // captured item is a close
    logic reject;        // captured item is a duplicate or out of window
    logic head_valid;    // head slot holds the expected sequence
    logic release_last;  // current release ends the drain
    logic out_free;      // output register can take a result this cycle
  } srb_status_t;

endpackage : srb_pkg

`default_nettype wire

FILE: design/sequence_reorder_buffer.sv
// ----------------------------------------------------------------------------
// sequence_reorder_buffer: in-order release of sequence-tagged results
// Holds out-of-order results in a 16-entry window and releases them in order.
// ----------------------------------------------------------------------------
// One input transfer is taken at a time. A close, a duplicate or an
// out-of-window item passes capture and evaluation, where it waits for a
// free output register, and yields one result. A stored item is written to
// its slot in evaluation and then releases consecutive entries from the
// head (at most 16 per input); an item that lands behind a gap releases
// nothing and yields no result. The drain emits one entry per cycle through
// the output register, so a stalled output slows the drain one for one. The
// window occupancy is cleared at once by reset and by a close; no clearing
// pass is needed. A new input is taken while the last result still waits in
// the output register.
`default_nettype none

module sequence_reorder_buffer
  import srb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                op_i,
  input  wire logic [SEQ_W-1:0]    seq_i,
  input  wire logic [PAY_W-1:0]    payload_i,
  input  wire logic                ok_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [SEQ_W-1:0]         out_seq_o,
  output logic [PAY_W-1:0]         out_payload_o,
  output logic                     out_ok_o,
  output logic                     last_o,
  output logic [COUNT_W-1:0]       decoded_count_o,
  output logic [COUNT_W-1:0]       rejected_count_o
);

  srb_cmd_t    cmd;
  srb_status_t dp_status;

  // controller
  srb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // datapath
  srb_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (dp_status),
    .op_i             (op_i),
    .seq_i            (seq_i),
    .payload_i        (payload_i),
    .ok_i             (ok_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_code_o    (status_o),
    .out_seq_o        (out_seq_o),
    .out_payload_o    (out_payload_o),
    .out_ok_o         (out_ok_o),
    .last_o           (last_o),
    .decoded_count_o  (decoded_count_o),
    .rejected_count_o (rejected_count_o)
  );

endmodule : sequence_reorder_buffer

`default_nettype wire

FILE: design/srb_ctrl.sv
// ----------------------------------------------------------------------------
// srb_ctrl: controller of the sequence reorder buffer
// Sequences acceptance, evaluation and the in-order drain of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_ctrl
  import srb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire srb_status_t status_i,
  output srb_cmd_t         cmd_o
);

  // state codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status_i.is_close) begin
          if (status_i.out_free) begin
            cmd_o.emit_close = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (status_i.reject) begin
          if (status_i.out_free) begin
            cmd_o.emit_reject = 1'b1;
            state_d           = S_IDLE;
          end
        end else begin
          cmd_o.store_write = 1'b1;
          state_d           = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status_i.head_valid) begin
          if (status_i.out_free) begin
            cmd_o.emit_release = 1'b1;
            if (status_i.release_last) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : srb_ctrl

`default_nettype wire

FILE: design/srb_dpath.sv
// ----------------------------------------------------------------------------
// srb_dpath: datapath of the sequence reorder buffer
// Input capture, window store, expected sequence, counters and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_dpath
  import srb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire srb_cmd_t            cmd_i,
  output srb_status_t              status_o,
  input  wire logic                op_i,
  input  wire logic [SEQ_W-1:0]    seq_i,
  input  wire logic [PAY_W-1:0]    payload_i,
  input  wire logic                ok_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [STATUS_W-1:0]      status_code_o,
  output logic [SEQ_W-1:0]         out_seq_o,
  output logic [PAY_W-1:0]         out_payload_o,
  output logic                     out_ok_o,
  output logic                     last_o,
  output logic [COUNT_W-1:0]       decoded_count_o,
  output logic [COUNT_W-1:0]       rejected_count_o
);

  localparam logic [IDX_W:0]   WIN_EXT  = (IDX_W+1)'(WINDOW);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);
  localparam logic [SEQ_W-1:0] SEQ_WIN  = SEQ_W'(WINDOW);

  // captured input
  logic             op_q;
  logic [SEQ_W-1:0] seq_q;
  logic [PAY_W-1:0] payload_q;
  logic             ok_q;

  // window state
  logic [SEQ_W-1:0]   expected_q;
  logic [IDX_W-1:0]   head_q;
  logic [WINDOW-1:0]  valid_q;
  logic [PAY_W-1:0]   slot_payload_q [WINDOW];
  logic               slot_ok_q      [WINDOW];
  logic [COUNT_W-1:0] decoded_q, rejected_q;
  logic [CNT_W-1:0]   drain_cnt_q;

  // output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SEQ_W-1:0]    out_seq_q;
  logic [PAY_W-1:0]    out_payload_q;
  logic                out_ok_q;
  logic                out_last_q;
  logic [COUNT_W-1:0]  out_dec_q, out_rej_q;

  logic [SEQ_W-1:0]    seq_ahead;
  logic                in_window;
  logic [IDX_W:0]      idx_sum;
  logic [IDX_W-1:0]    slot_idx;
  logic [IDX_W-1:0]    head_next;
  logic                head_ok;
  logic [COUNT_W-1:0]  decoded_d, rejected_d;
  logic                emit;

  // distance ahead of the expected sequence and target slot
  always_comb begin
    seq_ahead = seq_q - expected_q;
    in_window = (seq_ahead < SEQ_WIN);
    idx_sum   = {1'b0, head_q} + {1'b0, seq_ahead[IDX_W-1:0]};
    if (idx_sum >= WIN_EXT) begin
      idx_sum = idx_sum - WIN_EXT;
    end
    slot_idx = idx_sum[IDX_W-1:0];
  end

  // head advance and counter update on a release
  always_comb begin
    head_next  = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
    head_ok    = slot_ok_q[head_q];
    decoded_d  = decoded_q  + COUNT_W'(head_ok);
    rejected_d = rejected_q + COUNT_W'(!head_ok);
  end

  // status toward the controller
  always_comb begin
    status_o.is_close     = (op_q == OP_CLOSE);
    status_o.reject       = !in_window || valid_q[slot_idx];
    status_o.head_valid   = valid_q[head_q];
    status_o.release_last = !valid_q[head_next] || (drain_cnt_q == CNT_LAST);
    status_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign emit = cmd_i.emit_close | cmd_i.emit_reject | cmd_i.emit_release;

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q      <= op_i;
      seq_q     <= seq_i;
      payload_q <= payload_i;
      ok_q      <= ok_i;
    end
  end

  // slot data, read only where the valid bit is set
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_write) begin
      slot_payload_q[slot_idx] <= payload_q;
      slot_ok_q[slot_idx]      <= ok_q;
    end
  end

  // window control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q  <= '0;
      head_q      <= '0;
      valid_q     <= '0;
      decoded_q   <= '0;
      rejected_q  <= '0;
      drain_cnt_q <= '0;
    end else begin
      if (cmd_i.emit_close) begin
        expected_q <= '0;
        head_q     <= '0;
        valid_q    <= '0;
      end
      if (cmd_i.store_write) begin
        valid_q[slot_idx] <= 1'b1;
        drain_cnt_q       <= '0;
      end
      if (cmd_i.emit_release) begin
        valid_q[head_q] <= 1'b0;
        expected_q      <= expected_q + 1'b1;
        head_q          <= head_next;
        decoded_q       <= decoded_d;
        rejected_q      <= rejected_d;
        drain_cnt_q     <= drain_cnt_q + 1'b1;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_close) begin
      out_status_q  <= (valid_q != '0) ? ST_CLOSED_GAP : ST_CLOSED_OK;
      out_seq_q     <= expected_q;
      out_payload_q <= '0;
      out_ok_q      <= 1'b0;
      out_last_q    <= 1'b1;
      out_dec_q     <= decoded_q;
      out_rej_q     <= rejected_q;
    end else if (cmd_i.emit_reject) begin
      out_status_q  <= in_window ? ST_DUPLICATE : ST_OUT_OF_WIN;
      out_seq_q     <= seq_q;
      out_payload_q <= '0;
      out_ok_q      <= 1'b0;
      out_last_q    <= 1'b1;
      out_dec_q     <= decoded_q;
      out_rej_q     <= rejected_q;
    end else if (cmd_i.emit_release) begin
      out_status_q  <= ST_RELEASED;
      out_seq_q     <= expected_q;
      out_payload_q <= slot_payload_q[head_q];
      out_ok_q      <= head_ok;
      out_last_q    <= status_o.release_last;
      out_dec_q     <= decoded_d;
      out_rej_q     <= rejected_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_code_o    = out_status_q;
  assign out_seq_o        = out_seq_q;
  assign out_payload_o    = out_payload_q;
  assign out_ok_o         = out_ok_q;
  assign last_o           = out_last_q;
  assign decoded_count_o  = out_dec_q;
  assign rejected_count_o = out_rej_q;

endmodule : srb_dpath

`default_nettype wire
